// ----- hw/rtl/phtc_pkg.sv -----
`timescale 1ns / 1ps

package phtc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SOURCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEADING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_PERIOD = 3'd6;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned DERIV_W = 35;
  localparam int unsigned ACC_W   = 65;
  localparam int unsigned MUL_W   = 16;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned PWR_W   = 8;

  localparam logic [CNT_W-1:0] MUL_LAST = 4'd15;

  // gains are Q8.8, integral Q.16, derivative Q.6: align to Q.24
  localparam int unsigned P_SHIFT   = 16;
  localparam int unsigned D_SHIFT   = 10;
  localparam int unsigned DRIVE_SHIFT = 24;
  localparam int signed   DRIVE_LIMIT = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRAP,
    ST_INTEG,
    ST_DERIV,
    ST_GAINP,
    ST_GAINI,
    ST_GAIND,
    ST_DRIVE
  } state_e;

endpackage

// ----- hw/rtl/pid_heading_turn_controller.sv -----
`timescale 1ns / 1ps

// PID heading controller with trapezoidal integral.
// Input channel: in_valid_i / in_stall_o carry one heading sample
// (measured_angle_i) per item. Output channel: out_valid_o / out_stall_i
// carry left_power_o, right_power_o and finished_o, one result per item.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Indexes beyond the register list are ignored.
// All products run through one shared shift-add multiplier that consumes
// one multiplier bit per cycle: five 16-bit products (trapezoid,
// derivative, P, I and D terms) plus an integral step and a drive step.
// The block returns to idle only when the result is registered, so it
// takes no new sample before it is through with the last one.
// Reset clears the cfg registers, the error history, the integral and the
// sticky finished flag. A result waits in the output register while the
// receiver stalls; the block still accepts and processes the next sample
// and holds its result in the drive step until the output register frees.
module pid_heading_turn_controller (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [phtc_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [phtc_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [phtc_pkg::ANGLE_W-1:0]      measured_angle_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [phtc_pkg::PWR_W-1:0]        left_power_o,
  output logic signed [phtc_pkg::PWR_W-1:0]        right_power_o,
  output logic                                     finished_o
);
  import phtc_pkg::*;

  state_e state_q, state_d;

  logic                      src_q;
  logic signed [ANGLE_W-1:0] target_q;
  logic [MUL_W-1:0]          gain_p_q, gain_i_q, gain_d_q;
  logic [MUL_W-1:0]          period_q, inv_period_q;

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [ACC_W-1:0]   mcand_q, mcand_d;
  logic [MUL_W-1:0]          mplier_q, mplier_d;
  logic                      sgn_q, sgn_d;
  logic signed [ERR_W-1:0]   e_q, e_d;
  logic signed [ERR_W-1:0]   prev_q, prev_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [DERIV_W-1:0] deriv_q, deriv_d;
  logic                      done_q, done_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [PWR_W-1:0]   left_q, left_d, right_q, right_d;
  logic                      fin_q, fin_d;

  logic signed [ERR_W-1:0]     sample_s, target_s, e_new;
  logic signed [ERR_W:0]       e_sum, e_diff;
  logic signed [ACC_W-1:0]     addend, step_sum;
  logic                        last;
  logic signed [DERIV_W-2:0]   trap;
  logic signed [INTEG_W:0]     integ_sum;
  logic signed [ACC_W-DRIVE_SHIFT-1:0] q_floor, q_tz;
  logic                        round_up;
  logic signed [PWR_W-1:0]     drive;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q        <= 1'b0;
      target_q     <= '0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      period_q     <= '0;
      inv_period_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANGLE_SOURCE:   src_q        <= cfg_data_i[0];
        CFG_TARGET_HEADING: target_q     <= cfg_data_i;
        CFG_GAIN_P:         gain_p_q     <= cfg_data_i;
        CFG_GAIN_I:         gain_i_q     <= cfg_data_i;
        CFG_GAIN_D:         gain_d_q     <= cfg_data_i;
        CFG_SAMPLE_PERIOD:  period_q     <= cfg_data_i;
        CFG_INVERSE_PERIOD: inv_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sgn_q       <= 1'b0;
      prev_q      <= '0;
      integ_q     <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sgn_q       <= sgn_d;
      prev_q      <= prev_d;
      integ_q     <= integ_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    e_q      <= e_d;
    deriv_q  <= deriv_d;
    left_q   <= left_d;
    right_q  <= right_d;
    fin_q    <= fin_d;
  end

  always_comb begin
    sample_s = src_q ? ERR_W'(measured_angle_i) : -ERR_W'(measured_angle_i);
    target_s = ERR_W'(target_q);
    e_new    = sample_s - target_s;
    e_sum    = (ERR_W+1)'(e_new) + (ERR_W+1)'(prev_q);
    e_diff   = (ERR_W+1)'(e_q) - (ERR_W+1)'(prev_q);

    last     = (cnt_q == MUL_LAST);
    addend   = mplier_q[0] ? mcand_q : '0;
    step_sum = (sgn_q && last) ? acc_q - addend : acc_q + addend;

    // trapezoid halved with floor
    trap      = acc_q[DERIV_W-1:1];
    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(trap);

    // truncate toward zero, then clamp
    q_floor  = acc_q[ACC_W-1:DRIVE_SHIFT];
    round_up = acc_q[ACC_W-1] && (|acc_q[DRIVE_SHIFT-1:0]);
    q_tz     = q_floor + (ACC_W-DRIVE_SHIFT)'({1'b0, round_up});
    if (q_tz > (ACC_W-DRIVE_SHIFT)'(DRIVE_LIMIT)) begin
      drive = PWR_W'(DRIVE_LIMIT);
    end else if (q_tz < (ACC_W-DRIVE_SHIFT)'(-DRIVE_LIMIT)) begin
      drive = PWR_W'(-DRIVE_LIMIT);
    end else begin
      drive = q_tz[PWR_W-1:0];
    end

    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    sgn_d       = sgn_q;
    e_d         = e_q;
    prev_d      = prev_q;
    integ_d     = integ_q;
    deriv_d     = deriv_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    left_d      = left_q;
    right_d     = right_q;
    fin_d       = fin_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          e_d      = e_new;
          if (sample_s == target_s) begin
            done_d = 1'b1;
          end
          acc_d    = '0;
          cnt_d    = '0;
          mcand_d  = ACC_W'(e_sum);
          mplier_d = period_q;
          sgn_d    = 1'b0;
          state_d  = ST_TRAP;
        end
      end
      ST_TRAP, ST_DERIV, ST_GAINP, ST_GAINI, ST_GAIND: begin
        acc_d    = step_sum;
        mcand_d  = mcand_q <<< 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (last) begin
          case (state_q)
            ST_TRAP: begin
              state_d = ST_INTEG;
            end
            ST_DERIV: begin
              deriv_d  = step_sum[DERIV_W-1:0];
              acc_d    = '0;
              mcand_d  = ACC_W'(e_q) <<< P_SHIFT;
              mplier_d = gain_p_q;
              sgn_d    = 1'b1;
              state_d  = ST_GAINP;
            end
            ST_GAINP: begin
              mcand_d  = ACC_W'(integ_q);
              mplier_d = gain_i_q;
              state_d  = ST_GAINI;
            end
            ST_GAINI: begin
              mcand_d  = ACC_W'(deriv_q) <<< D_SHIFT;
              mplier_d = gain_d_q;
              state_d  = ST_GAIND;
            end
            default: begin
              sgn_d   = 1'b0;
              state_d = ST_DRIVE;
            end
          endcase
        end
      end
      ST_INTEG: begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
          integ_d = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                       : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
          integ_d = integ_sum[INTEG_W-1:0];
        end
        acc_d    = '0;
        mcand_d  = ACC_W'(e_diff);
        mplier_d = inv_period_q;
        sgn_d    = 1'b0;
        state_d  = ST_DERIV;
      end
      ST_DRIVE: begin
        if (!out_valid_d) begin
          out_valid_d = 1'b1;
          right_d     = drive;
          left_d      = -drive;
          fin_d       = done_q;
          prev_d      = e_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign left_power_o  = left_q;
  assign right_power_o = right_q;
  assign finished_o    = fin_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_TRAP)
    else $error("accepted item did not start the trapezoid product");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("finished flag cleared without reset");

  a_power_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_power_o == -right_power_o) &&
                    (right_power_o <= 8'sd100) && (right_power_o >= -8'sd100))
    else $error("left and right power out of range or not mirrored");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INTEG || state_q == ST_DRIVE) |-> cnt_q == '0)
    else $error("bit counter not aligned at product boundary");
`endif

endmodule
